// ----- rtl/fbcc_pkg.sv -----
// fbcc_pkg: shared types, character codes and the symbol decoder for the
// fasta base composition counter. No dependencies.
package fbcc_pkg;

	localparam int COUNT_WIDTH_DEF      = 32;
	localparam int HEADER_LEN_WIDTH_DEF = 16;

	localparam int FIELD_CNT_W = 32;
	localparam int FIELD_HDR_W = 16;
	localparam int TDATA_W     = 10 * FIELD_CNT_W + FIELD_HDR_W - FIELD_CNT_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_SEQUENCE = 1'b0;
	localparam logic KIND_FILE     = 1'b1;

	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_GT      = 8'h3e;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_GAP   = 8'h20;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_K = 8'h4b;
	localparam logic [7:0] CH_M = 8'h4d;
	localparam logic [7:0] CH_N = 8'h4e;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_V = 8'h56;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_Y = 8'h59;

	localparam logic [3:0] BASE_NONE = 4'b0000;
	localparam logic [3:0] BASE_A    = 4'b0001;
	localparam logic [3:0] BASE_C    = 4'b0010;
	localparam logic [3:0] BASE_G    = 4'b0100;
	localparam logic [3:0] BASE_T    = 4'b1000;

	typedef struct packed {
		logic                   has_sum;
		logic [FIELD_CNT_W-1:0] sum_seq;
		logic [FIELD_CNT_W-1:0] sum_lines;
		logic [FIELD_CNT_W-1:0] sum_anom;
		logic                   has_rec;
		logic                   rec_last;
		logic [FIELD_CNT_W-1:0] rec_seq;
		logic [FIELD_HDR_W-1:0] rec_hdr;
		logic [FIELD_CNT_W-1:0] rec_total;
		logic [FIELD_CNT_W-1:0] rec_a;
		logic [FIELD_CNT_W-1:0] rec_c;
		logic [FIELD_CNT_W-1:0] rec_g;
		logic [FIELD_CNT_W-1:0] rec_t;
		logic [FIELD_CNT_W-1:0] rec_other;
	} q_entry_t;

	// one bit per base, iupac letters set several
	function automatic logic [3:0] decode_symbol(input logic [7:0] b);
		logic [7:0] u;
		logic [3:0] m;
		begin
			u = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_GAP : b;
			unique case (u)
				CH_A:    m = BASE_A;
				CH_C:    m = BASE_C;
				CH_G:    m = BASE_G;
				CH_T:    m = BASE_T;
				CH_M:    m = BASE_A | BASE_C;
				CH_R:    m = BASE_A | BASE_G;
				CH_W:    m = BASE_A | BASE_T;
				CH_S:    m = BASE_C | BASE_G;
				CH_Y:    m = BASE_C | BASE_T;
				CH_K:    m = BASE_G | BASE_T;
				CH_V:    m = BASE_A | BASE_C | BASE_G;
				CH_H:    m = BASE_A | BASE_C | BASE_T;
				CH_D:    m = BASE_A | BASE_G | BASE_T;
				CH_B:    m = BASE_C | BASE_G | BASE_T;
				CH_N:    m = BASE_A | BASE_C | BASE_G | BASE_T;
				default: m = BASE_NONE;
			endcase
			return m;
		end
	endfunction

endpackage

// ----- rtl/fbcc_core.sv -----
// fbcc_core: input register, record and file counters, and the builder of
// queue entries. Depends on fbcc_pkg.
module fbcc_core #(
	parameter int COUNT_WIDTH      = fbcc_pkg::COUNT_WIDTH_DEF,
	parameter int HEADER_LEN_WIDTH = fbcc_pkg::HEADER_LEN_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_eos,
	input  logic               can_push,
	output logic               push,
	output fbcc_pkg::q_entry_t entry
);
	import fbcc_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int HW = HEADER_LEN_WIDTH;

	function automatic logic [CW-1:0] inc_cnt(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [HW-1:0] inc_hdr(input logic [HW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eos_s1;

	logic          in_header_q, at_line_start_q, record_open_q;
	logic [CW-1:0] record_index_q;
	logic [HW-1:0] header_len_q;
	logic [CW-1:0] symbol_total_q;
	logic [CW-1:0] base_q [4];
	logic [CW-1:0] other_q, line_q, anom_q;

	logic          in_header_d, at_line_start_d, record_open_d;
	logic [CW-1:0] record_index_d;
	logic [HW-1:0] header_len_d;
	logic [CW-1:0] symbol_total_d;
	logic [CW-1:0] base_d [4];
	logic [CW-1:0] other_d, line_d, anom_d;

	logic          is_nl, hdr_open, emit_rec, emit_sum, advance;
	logic [CW-1:0] anom_closed;
	logic [3:0]    sym_mask;

	assign is_nl       = byte_s1 == CH_NL;
	assign hdr_open    = at_line_start_q && (byte_s1 == CH_GT);
	assign emit_rec    = valid_s1 && record_open_q && (eos_s1 || (!is_nl && hdr_open));
	assign emit_sum    = valid_s1 && eos_s1;
	assign advance     = valid_s1 && (!(emit_rec || emit_sum) || can_push);
	assign in_ready    = !valid_s1 || advance;
	assign push        = advance && (emit_rec || emit_sum);
	assign sym_mask    = decode_symbol(byte_s1);
	assign anom_closed = (record_open_q && other_q != '0) ? inc_cnt(anom_q) : anom_q;

	always_comb begin
		entry.has_rec   = emit_rec;
		entry.rec_last  = !eos_s1;
		entry.rec_seq   = FIELD_CNT_W'(record_index_q - 1'b1);
		entry.rec_hdr   = FIELD_HDR_W'(header_len_q);
		entry.rec_total = FIELD_CNT_W'(symbol_total_q);
		entry.rec_a     = FIELD_CNT_W'(base_q[0]);
		entry.rec_c     = FIELD_CNT_W'(base_q[1]);
		entry.rec_g     = FIELD_CNT_W'(base_q[2]);
		entry.rec_t     = FIELD_CNT_W'(base_q[3]);
		entry.rec_other = FIELD_CNT_W'(other_q);
		entry.has_sum   = emit_sum;
		entry.sum_seq   = FIELD_CNT_W'(record_index_q);
		entry.sum_lines = FIELD_CNT_W'(line_q);
		entry.sum_anom  = FIELD_CNT_W'(anom_closed);
	end

	always_comb begin
		in_header_d     = in_header_q;
		at_line_start_d = at_line_start_q;
		record_open_d   = record_open_q;
		record_index_d  = record_index_q;
		header_len_d    = header_len_q;
		symbol_total_d  = symbol_total_q;
		for (int i = 0; i < 4; i++) begin
			base_d[i] = base_q[i];
		end
		other_d = other_q;
		line_d  = line_q;
		anom_d  = anom_q;
		if (eos_s1) begin
			in_header_d     = 1'b0;
			at_line_start_d = 1'b1;
			record_open_d   = 1'b0;
			record_index_d  = '0;
			header_len_d    = '0;
			symbol_total_d  = '0;
			for (int i = 0; i < 4; i++) begin
				base_d[i] = '0;
			end
			other_d = '0;
			line_d  = '0;
			anom_d  = '0;
		end else if (is_nl) begin
			in_header_d     = 1'b0;
			at_line_start_d = 1'b1;
			line_d          = inc_cnt(line_q);
		end else if (hdr_open) begin
			anom_d          = anom_closed;
			header_len_d    = '0;
			symbol_total_d  = '0;
			for (int i = 0; i < 4; i++) begin
				base_d[i] = '0;
			end
			other_d         = '0;
			record_index_d  = inc_cnt(record_index_q);
			record_open_d   = 1'b1;
			in_header_d     = 1'b1;
			at_line_start_d = 1'b0;
		end else begin
			at_line_start_d = 1'b0;
			if (in_header_q) begin
				header_len_d = inc_hdr(header_len_q);
			end else if (record_open_q) begin
				if (sym_mask == BASE_NONE) begin
					other_d = inc_cnt(other_q);
				end else begin
					symbol_total_d = inc_cnt(symbol_total_q);
					for (int i = 0; i < 4; i++) begin
						if (sym_mask[i]) begin
							base_d[i] = inc_cnt(base_q[i]);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= in_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q     <= 1'b0;
			at_line_start_q <= 1'b1;
			record_open_q   <= 1'b0;
			record_index_q  <= '0;
			header_len_q    <= '0;
			symbol_total_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				base_q[i] <= '0;
			end
			other_q <= '0;
			line_q  <= '0;
			anom_q  <= '0;
		end else if (advance) begin
			in_header_q     <= in_header_d;
			at_line_start_q <= at_line_start_d;
			record_open_q   <= record_open_d;
			record_index_q  <= record_index_d;
			header_len_q    <= header_len_d;
			symbol_total_q  <= symbol_total_d;
			for (int i = 0; i < 4; i++) begin
				base_q[i] <= base_d[i];
			end
			other_q <= other_d;
			line_q  <= line_d;
			anom_q  <= anom_d;
		end
	end

	a_open_has_index: assert property (@(posedge clk) disable iff (!arst_n)
		record_open_q |-> record_index_q != '0)
		else $error("open record with zero index");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> !record_open_q && record_index_q == '0 && at_line_start_q)
		else $error("end of file did not clear state");

	a_sum_only_on_eos: assert property (@(posedge clk) disable iff (!arst_n)
		push && entry.has_sum |-> entry.rec_last == 1'b0 || !entry.has_rec)
		else $error("record before file summary flagged last");

endmodule

// ----- rtl/fbcc_out_queue.sv -----
// fbcc_out_queue: two-entry result queue that unpacks each entry into one
// or two output transactions. Depends on fbcc_pkg.
module fbcc_out_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  fbcc_pkg::q_entry_t           entry,
	output logic                         can_push,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [fbcc_pkg::TDATA_W-1:0] m_axis_tdata, // seq, hdr len, total, a, c, g, t, other, lines, anomalous
	output logic                         m_axis_tuser, // record kind
	output logic                         m_axis_tlast
);
	import fbcc_pkg::*;

	q_entry_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              phase_q;

	q_entry_t head;
	logic     show_rec, take, pop_entry;

	assign head      = ent_q[rd_ptr_q];
	assign show_rec  = head.has_rec && !phase_q;
	assign take      = m_axis_tvalid && m_axis_tready;
	assign pop_entry = take && (!show_rec || !head.has_sum);
	assign can_push  = (cnt_q != QCNT_W'(QUEUE_DEPTH)) || pop_entry;

	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tuser  = show_rec ? KIND_SEQUENCE : KIND_FILE;
	assign m_axis_tlast  = show_rec ? head.rec_last : 1'b1;

	always_comb begin
		if (show_rec) begin
			m_axis_tdata = {{(2 * FIELD_CNT_W){1'b0}}, head.rec_other, head.rec_t, head.rec_g,
				head.rec_c, head.rec_a, head.rec_total, head.rec_hdr, head.rec_seq};
		end else begin
			m_axis_tdata = {head.sum_anom, head.sum_lines, {(6 * FIELD_CNT_W + FIELD_HDR_W){1'b0}},
				head.sum_seq};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_entry) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop_entry) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop_entry) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (take) begin
				phase_q <= !pop_entry;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != QCNT_W'(QUEUE_DEPTH) || pop_entry)
		else $error("result queue overflow");

	a_phase_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> cnt_q != '0 && head.has_rec && head.has_sum)
		else $error("second phase without a pair");

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> head.has_rec || head.has_sum)
		else $error("empty entry in result queue");

endmodule

// ----- rtl/fasta_base_composition_counter_unit.sv -----
// fasta_base_composition_counter_unit: top level of the fasta base composition counter.
// Path: each byte passes through the input register in fbcc_core and the result queue
// before its results are offered on the output.
// Throughput: one byte per cycle while the result queue can take entries; an end of file
// with an open record yields two output transactions.
// Reset: arst_n clears all counters and flags and empties the result queue.
module fasta_base_composition_counter_unit #(
	parameter int COUNT_WIDTH      = fbcc_pkg::COUNT_WIDTH_DEF,
	parameter int HEADER_LEN_WIDTH = fbcc_pkg::HEADER_LEN_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata, // data_byte
	input  logic                         s_axis_tlast, // end_of_stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [fbcc_pkg::TDATA_W-1:0] m_axis_tdata, // sequence_number, header_length,
	// total_symbols, count_a, count_c, count_g, count_t, other_count, lines_seen,
	// anomalous_sequences
	output logic                         m_axis_tuser, // record_kind
	output logic                         m_axis_tlast  // last
);
	import fbcc_pkg::*;

	q_entry_t entry;
	logic     push, can_push;

	fbcc_core #(
		.COUNT_WIDTH      (COUNT_WIDTH),
		.HEADER_LEN_WIDTH (HEADER_LEN_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eos   (s_axis_tlast),
		.can_push (can_push),
		.push     (push),
		.entry    (entry)
	);

	fbcc_out_queue u_out_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.entry         (entry),
		.can_push      (can_push),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- verif/tb_fasta_base_composition_counter_unit.sv -----
// tb_fasta_base_composition_counter_unit: self-checking bench for the fasta base composition
// counter, driving multi-fasta byte streams and checking every summary transaction.
// Depends on fbcc_pkg and fasta_base_composition_counter_unit.
`timescale 1ns / 100ps

module tb_fasta_base_composition_counter_unit;
	import fbcc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} fasta_byte_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] seq;
		logic [15:0] hdr;
		logic [31:0] total;
		logic [31:0] a;
		logic [31:0] c;
		logic [31:0] g;
		logic [31:0] t;
		logic [31:0] other;
		logic [31:0] lines;
		logic [31:0] anom;
		logic        last;
	} summary_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;

	fasta_byte_t stim_q[$];
	summary_t    expected_q[$];
	int          errors = 0;

	// composition state of the file being parsed
	logic        hdr_active;
	logic        line_start;
	logic        rec_open;
	logic [31:0] rec_idx;
	logic [15:0] hdr_len;
	logic [31:0] sym_total;
	logic [31:0] base_tally[4];
	logic [31:0] other_tally;
	logic [31:0] line_tally;
	logic [31:0] anom_tally;

	int  send_gap;
	bit  send_calm;
	int  recv_hold;
	bit  recv_calm;
	int  results_taken;

	fasta_base_composition_counter_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] sat_up(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// bases covered by a nucleotide or iupac letter, either case
	function automatic logic [3:0] iupac_bases(input logic [7:0] b);
		logic [7:0] u;
		u = b;
		if (b >= "a" && b <= "z") begin
			u = b & 8'hdf;
		end
		case (u)
			"A": return BASE_A;
			"C": return BASE_C;
			"G": return BASE_G;
			"T": return BASE_T;
			"M": return BASE_A | BASE_C;
			"R": return BASE_A | BASE_G;
			"W": return BASE_A | BASE_T;
			"S": return BASE_C | BASE_G;
			"Y": return BASE_C | BASE_T;
			"K": return BASE_G | BASE_T;
			"V": return BASE_A | BASE_C | BASE_G;
			"H": return BASE_A | BASE_C | BASE_T;
			"D": return BASE_A | BASE_G | BASE_T;
			"B": return BASE_C | BASE_G | BASE_T;
			"N": return BASE_A | BASE_C | BASE_G | BASE_T;
			default: return BASE_NONE;
		endcase
	endfunction

	function automatic int pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic start_file();
		hdr_active = 1'b0;
		line_start = 1'b1;
		rec_open = 1'b0;
		rec_idx = '0;
		hdr_len = '0;
		sym_total = '0;
		for (int i = 0; i < 4; i++) begin
			base_tally[i] = '0;
		end
		other_tally = '0;
		line_tally = '0;
		anom_tally = '0;
	endtask

	task automatic close_record(input logic is_last);
		summary_t s;
		s = '0;
		s.kind = KIND_SEQUENCE;
		s.seq = (rec_idx != 0) ? rec_idx - 32'd1 : '0;
		s.hdr = hdr_len;
		s.total = sym_total;
		s.a = base_tally[0];
		s.c = base_tally[1];
		s.g = base_tally[2];
		s.t = base_tally[3];
		s.other = other_tally;
		s.last = is_last;
		expected_q.push_back(s);
		if (other_tally != 0) begin
			anom_tally = sat_up(anom_tally);
		end
		rec_open = 1'b0;
	endtask

	task automatic account_byte(input logic [7:0] b, input logic eos);
		summary_t   s;
		logic [3:0] m;
		if (eos) begin
			if (rec_open) begin
				close_record(1'b0);
			end
			s = '0;
			s.kind = KIND_FILE;
			s.seq = rec_idx;
			s.lines = line_tally;
			s.anom = anom_tally;
			s.last = 1'b1;
			expected_q.push_back(s);
			start_file();
		end else if (b == CH_NL) begin
			hdr_active = 1'b0;
			line_start = 1'b1;
			line_tally = sat_up(line_tally);
		end else if (line_start && b == CH_GT) begin
			if (rec_open) begin
				close_record(1'b1);
			end
			hdr_len = '0;
			sym_total = '0;
			for (int i = 0; i < 4; i++) begin
				base_tally[i] = '0;
			end
			other_tally = '0;
			rec_idx = sat_up(rec_idx);
			rec_open = 1'b1;
			hdr_active = 1'b1;
			line_start = 1'b0;
		end else begin
			line_start = 1'b0;
			if (hdr_active) begin
				if (hdr_len != '1) begin
					hdr_len = hdr_len + 16'd1;
				end
			end else if (rec_open) begin
				m = iupac_bases(b);
				if (m == BASE_NONE) begin
					other_tally = sat_up(other_tally);
				end else begin
					sym_total = sat_up(sym_total);
					for (int i = 0; i < 4; i++) begin
						if (m[i]) begin
							base_tally[i] = sat_up(base_tally[i]);
						end
					end
				end
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic eos = 1'b0);
		fasta_byte_t it;
		it.data = b;
		it.eos = eos;
		stim_q.push_back(it);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// driver: offers queued bytes, with random idle gaps between transactions
	always @(posedge clk or negedge arst_n) begin : drive
		int          gap;
		fasta_byte_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			send_gap <= 0;
			send_calm <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			gap = send_gap;
			if (s_axis_tvalid) begin
				account_byte(s_axis_tdata, s_axis_tlast);
				if ($urandom_range(0, 60) == 0) begin
					send_calm <= !send_calm;
				end
				gap = pick_wait(send_calm);
			end
			if (gap == 0 && stim_q.size() > 0) begin
				it = stim_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= it.data;
				s_axis_tlast <= it.eos;
				send_gap <= 0;
			end else begin
				s_axis_tvalid <= 1'b0;
				send_gap <= (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	// monitor: checks each summary transaction and stalls the output at random
	always @(posedge clk or negedge arst_n) begin : watch
		int       hold;
		summary_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_hold <= 0;
			recv_calm <= 1'b0;
			results_taken <= 0;
		end else begin
			hold = (recv_hold > 0) ? recv_hold - 1 : 0;
			if (m_axis_tvalid && m_axis_tready) begin
				results_taken <= results_taken + 1;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none, actual tdata %0h",
						$time, m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("record_kind", 32'(want.kind), 32'(m_axis_tuser));
					check_field("sequence_number", want.seq, m_axis_tdata[0 +: 32]);
					check_field("header_length", 32'(want.hdr), 32'(m_axis_tdata[32 +: 16]));
					check_field("total_symbols", want.total, m_axis_tdata[48 +: 32]);
					check_field("count_a", want.a, m_axis_tdata[80 +: 32]);
					check_field("count_c", want.c, m_axis_tdata[112 +: 32]);
					check_field("count_g", want.g, m_axis_tdata[144 +: 32]);
					check_field("count_t", want.t, m_axis_tdata[176 +: 32]);
					check_field("other_count", want.other, m_axis_tdata[208 +: 32]);
					check_field("lines_seen", want.lines, m_axis_tdata[240 +: 32]);
					check_field("anomalous_sequences", want.anom, m_axis_tdata[272 +: 32]);
					check_field("last", 32'(want.last), 32'(m_axis_tlast));
				end
				if ($urandom_range(0, 20) == 0) begin
					recv_calm <= !recv_calm;
				end
				// one long back-pressure stretch so the input side stalls
				hold = (results_taken == 25) ? 300 : pick_wait(recv_calm);
			end
			recv_hold <= hold;
			m_axis_tready <= (hold == 0);
		end
	end

	initial begin
		string       syms;
		int          nrec;
		int          nlines;
		int          len;
		logic [7:0]  b;
		syms = "ACGTMRWSYKVHDBNacgtmrwsykvhdbn";
		arst_n = 1'b0;
		start_file();

		// empty file, stray text before the first header, mixed symbols and noise,
		// a mid-line '>', an empty header and a flush with a record open
		push_byte(8'hff, 1'b1);
		push_byte("x");
		push_byte(CH_NL);
		push_byte(CH_GT);
		push_byte("h");
		push_byte("1");
		push_byte(CH_NL);
		push_byte("A");
		push_byte("c");
		push_byte("G");
		push_byte("t");
		push_byte("N");
		push_byte("r");
		push_byte(8'h00);
		push_byte(8'h0d);
		push_byte(" ");
		push_byte(CH_GT);
		push_byte(CH_NL);
		push_byte(CH_GT);
		push_byte(CH_NL);
		push_byte("y");
		push_byte(8'h00, 1'b1);

		while (stim_q.size() < 1010) begin
			if ($urandom_range(0, 9) == 0) begin
				// unstructured noise file
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					push_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				len = $urandom_range(0, 2);
				for (int i = 0; i < len; i++) begin
					push_byte(8'($urandom_range(0, 255)));
				end
				if (len > 0) begin
					push_byte(CH_NL);
				end
				nrec = $urandom_range(1, 5);
				for (int r = 0; r < nrec; r++) begin
					push_byte(CH_GT);
					len = $urandom_range(0, 10);
					for (int i = 0; i < len; i++) begin
						b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(32, 126));
						push_byte(b);
					end
					push_byte(CH_NL);
					nlines = $urandom_range(0, 3);
					for (int l = 0; l < nlines; l++) begin
						len = $urandom_range(1, 20);
						for (int i = 0; i < len; i++) begin
							if ($urandom_range(0, 11) == 0) begin
								b = 8'($urandom_range(0, 255));
							end else begin
								b = syms[$urandom_range(0, syms.len() - 1)];
							end
							push_byte(b);
						end
						if ($urandom_range(0, 5) == 0) begin
							push_byte(8'h0d);
						end
						if (l < nlines - 1 || $urandom_range(0, 3) != 0) begin
							push_byte(CH_NL);
						end
					end
				end
			end
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_fasta_base_composition_counter_unit: done, clean");
		end else begin
			$display("tb_fasta_base_composition_counter_unit: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_fasta_base_composition_counter_unit: done, errors");
		$finish;
	end

endmodule

// ----- fasta_base_composition_counter_unit.f -----
rtl/fbcc_pkg.sv
rtl/fbcc_core.sv
rtl/fbcc_out_queue.sv
rtl/fasta_base_composition_counter_unit.sv
verif/tb_fasta_base_composition_counter_unit.sv
